[sv/tga_rle_pixel_decoder_defines.svh]
// assertion macros for the tga decoder checker
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tga decoder check failed");

// condition holds in the cycle after the trigger
`define TRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tga decoder check failed");

`endif

[sv/trd_pkg.sv]
`timescale 1ns / 1ps

package trd_pkg;

  // dimension limit and register widths
  localparam int DIM_BITS   = 16;
  localparam int DIM_W      = 16;
  localparam int PIX_CNT_W  = 2 * DIM_W;
  localparam int GATHER_W   = 32;

  // byte queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // header byte positions
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP       = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  // header field codes
  localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
  localparam logic [7:0] IMG_TYPE_RLE = 8'd10;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [2:0] PIX_BYTES_24 = 3'd3;
  localparam logic [2:0] PIX_BYTES_32 = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PACKET,
    PH_PIXEL,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_ZERO_DIM,
    ST_CLIPPED
  } status_e;

  // one input beat as held in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } queue_entry_t;

  // parser state
  typedef struct packed {
    phase_e                 phase;
    logic [4:0]             hdr_pos;
    logic [7:0]             id_skip;
    logic                   compressed;
    logic [DIM_W-1:0]       width;
    logic [DIM_W-1:0]       height;
    logic [2:0]             pix_bytes;
    logic                   origin;
    logic [PIX_CNT_W-1:0]   pixels_left;
    logic                   pkt_run;
    logic [7:0]             pkt_left;
    logic [GATHER_W-1:0]    gather;
    logic [1:0]             byte_idx;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{
    phase:       PH_HEADER,
    hdr_pos:     5'd0,
    id_skip:     8'd0,
    compressed:  1'b0,
    width:       '0,
    height:      '0,
    pix_bytes:   PIX_BYTES_24,
    origin:      1'b0,
    pixels_left: '0,
    pkt_run:     1'b0,
    pkt_left:    8'd0,
    gather:      '0,
    byte_idx:    2'd0
  };

  // one result beat
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    status_e    status;
    logic       top_origin;
  } pixel_out_t;

endpackage

[sv/trd_front.sv]
`timescale 1ns / 1ps

module trd_front import trd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   data_byte_i,
  input  logic         start_of_file_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         q_valid_o,
  output queue_entry_t q_entry_o,
  input  logic         q_pop_i
);

  queue_entry_t            entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]       count_q, count_d;
  logic                    full;
  logic                    push;

  // accept a beat whenever there is room
  assign full       = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !full;
  assign in_stall_o = full;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entries_q[rd_ptr_q];

  // pointer and fill count update, depth is a power of two so pointers wrap
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{data: data_byte_i, restart: start_of_file_i};
    end
  end

endmodule

[sv/trd_back.sv]
`timescale 1ns / 1ps

module trd_back import trd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  queue_entry_t q_entry_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output pixel_out_t   res_o
);

  dec_state_t              st_q, st_d, cur;
  pixel_out_t              res_q, res;
  logic                    res_valid;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              b;
  logic                    err;
  status_e                 err_code;
  logic [PIX_CNT_W-1:0]    area;
  logic                    too_wide;
  logic [DIM_W-1:0]        height_full;
  logic [GATHER_W-1:0]     gather_new;
  logic [2:0]              idx_next;
  logic [7:0]              rep;
  logic                    clipped;
  logic [PIX_CNT_W-1:0]    pl_new;
  logic [7:0]              ppl_new;

  // move to pixel data once header and id field are done
  function automatic dec_state_t start_data(dec_state_t s);
    dec_state_t r;
    r          = s;
    r.byte_idx = 2'd0;
    r.gather   = '0;
    if (s.compressed) begin
      r.phase = PH_PACKET;
    end else begin
      r.phase    = PH_PIXEL;
      r.pkt_run  = 1'b0;
      r.pkt_left = 8'd0;
    end
    return r;
  endfunction

  // take a beat when the output register is free or being emptied
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign b       = q_entry_i.data;
  assign cur     = q_entry_i.restart ? DEC_RESET : st_q;

  // header helpers: pixel count and dimension limit
  assign height_full = {b, cur.height[7:0]};
  assign area        = PIX_CNT_W'(cur.width) * PIX_CNT_W'(cur.height);
  assign too_wide    = ((PIX_CNT_W'(cur.width) >> DIM_BITS) != '0) ||
                       ((PIX_CNT_W'(height_full) >> DIM_BITS) != '0);

  // pixel assembly and repeat count
  always_comb begin
    gather_new = cur.gather | (GATHER_W'(b) << {cur.byte_idx, 3'b000});
    idx_next   = {1'b0, cur.byte_idx} + 3'd1;
    clipped    = 1'b0;
    if (cur.compressed && cur.pkt_run) begin
      ppl_new = 8'd0;
      if (PIX_CNT_W'(cur.pkt_left) > cur.pixels_left) begin
        rep     = cur.pixels_left[7:0];
        clipped = 1'b1;
      end else begin
        rep = cur.pkt_left;
      end
      pl_new = cur.pixels_left - PIX_CNT_W'(rep);
    end else begin
      rep     = 8'd1;
      pl_new  = cur.pixels_left - PIX_CNT_W'(1);
      ppl_new = cur.pkt_left;
      if (cur.compressed) begin
        if (cur.pkt_left != 8'd0) begin
          ppl_new = cur.pkt_left - 8'd1;
        end
        if (pl_new == '0 && ppl_new != 8'd0) begin
          clipped = 1'b1;
        end
      end
    end
  end

  // parser next state and result
  always_comb begin
    st_d      = cur;
    res       = '0;
    res_valid = 1'b0;
    err       = 1'b0;
    err_code  = ST_BAD_HEADER;
    case (cur.phase)
      PH_HEADER: begin
        if (cur.hdr_pos < HDR_DESC) begin
          st_d.hdr_pos = cur.hdr_pos + 5'd1;
        end
        case (cur.hdr_pos)
          HDR_ID_LEN: begin
            st_d.id_skip = b;
          end
          HDR_CMAP_TYPE: begin
            if (b != 8'd0) begin
              err = 1'b1;
            end
          end
          HDR_IMG_TYPE: begin
            if (b == IMG_TYPE_RAW) begin
              st_d.compressed = 1'b0;
            end else if (b == IMG_TYPE_RLE) begin
              st_d.compressed = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          HDR_WIDTH_LO: begin
            st_d.width = DIM_W'(b);
          end
          HDR_WIDTH_HI: begin
            st_d.width = {b, cur.width[7:0]};
          end
          HDR_HEIGHT_LO: begin
            st_d.height = DIM_W'(b);
          end
          HDR_HEIGHT_HI: begin
            st_d.height = height_full;
            if (too_wide) begin
              err = 1'b1;
            end else if (cur.width == '0 || height_full == '0) begin
              err      = 1'b1;
              err_code = ST_ZERO_DIM;
            end
          end
          HDR_BPP: begin
            if (b == BPP_24) begin
              st_d.pix_bytes = PIX_BYTES_24;
            end else if (b == BPP_32) begin
              st_d.pix_bytes = PIX_BYTES_32;
            end else begin
              err = 1'b1;
            end
          end
          HDR_DESC: begin
            if (b[7:6] != 2'b00) begin
              err = 1'b1;
            end else begin
              st_d.origin      = b[5];
              st_d.pixels_left = area;
              if (cur.id_skip != 8'd0) begin
                st_d.phase = PH_IDSKIP;
              end else begin
                st_d = start_data(st_d);
              end
            end
          end
          default: ;
        endcase
      end
      PH_IDSKIP: begin
        st_d.id_skip = cur.id_skip - 8'd1;
        if (st_d.id_skip == 8'd0) begin
          st_d = start_data(st_d);
        end
      end
      PH_PACKET: begin
        st_d.pkt_run  = b[7];
        st_d.pkt_left = b[7] ? ({1'b0, b[6:0]} + 8'd1) : (b + 8'd1);
        st_d.byte_idx = 2'd0;
        st_d.gather   = '0;
        st_d.phase    = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (idx_next < cur.pix_bytes) begin
          st_d.gather   = gather_new;
          st_d.byte_idx = idx_next[1:0];
        end else begin
          st_d.gather      = '0;
          st_d.byte_idx    = 2'd0;
          st_d.pixels_left = pl_new;
          st_d.pkt_left    = ppl_new;
          res_valid        = 1'b1;
          res.red          = gather_new[23:16];
          res.green        = gather_new[15:8];
          res.blue         = gather_new[7:0];
          res.alpha        = (cur.pix_bytes == PIX_BYTES_32) ? gather_new[31:24] : 8'd0;
          res.repeat_count = rep;
          res.last_pixel   = (pl_new == '0);
          res.status       = clipped ? ST_CLIPPED : ST_OK;
          res.top_origin   = cur.origin;
          if (pl_new == '0) begin
            st_d.phase = PH_DONE;
          end else if (cur.compressed && ppl_new == 8'd0) begin
            st_d.phase = PH_PACKET;
          end
        end
      end
      default: ;
    endcase
    // error beat ends the image
    if (err) begin
      res_valid      = 1'b1;
      res            = '0;
      res.last_pixel = 1'b1;
      res.status     = err_code;
      res.top_origin = cur.origin;
      st_d.phase     = PH_DONE;
    end
  end

  // output register valid
  always_comb begin
    if (q_pop_o && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // parser state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= DEC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        st_q <= st_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[sv/tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps
// channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------------
// input    | in_valid_i / in_stall_o  | data_byte_i, start_of_file_i
// output   | out_valid_o / out_stall_i| red_o green_o blue_o alpha_o repeat_count_o
//          |                          | last_pixel_o status_o top_origin_o
// one byte per cycle sustained while the output is not stalled; a result's last byte
// goes through the queue write, then the parser step into the output register
// descriptor byte multiplies width by height (16 x 16) in the parser step
// reset clears the two-entry byte queue, the parser state and the output valid
// an output stall holds the result; the queue takes at most two more bytes, then stalls

module tga_rle_pixel_decoder import trd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_file_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic [7:0] repeat_count_o,
  output logic       last_pixel_o,
  output logic [1:0] status_o,
  output logic       top_origin_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_entry;
  pixel_out_t   res;

  // byte intake and queue
  trd_front u_front (
    .clk_i,
    .rst_ni,
    .data_byte_i,
    .start_of_file_i,
    .in_valid_i,
    .in_stall_o,
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  // header parser, packet decoder and output register
  trd_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .res_o     (res)
  );

  assign red_o          = res.red;
  assign green_o        = res.green;
  assign blue_o         = res.blue;
  assign alpha_o        = res.alpha;
  assign repeat_count_o = res.repeat_count;
  assign last_pixel_o   = res.last_pixel;
  assign status_o       = res.status;
  assign top_origin_o   = res.top_origin;

endmodule

[sv/trd_checker.sv]
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_defines.svh"

module trd_checker import trd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] data_byte_i,
  input logic       start_of_file_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o,
  input logic [7:0] repeat_count_o,
  input logic       last_pixel_o,
  input logic [1:0] status_o,
  input logic       top_origin_o,
  input logic       out_valid_o,
  input logic       out_stall_i
);

  // stalled result beat stays and keeps its pixel
  `TRD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(red_o) && $stable(repeat_count_o))

  // error beats carry no pixel and end the image
  `TRD_ASSERT_SAME(a_err_beat, out_valid_o && (status_o == ST_BAD_HEADER || status_o == ST_ZERO_DIM), repeat_count_o == 8'd0 && last_pixel_o && red_o == 8'd0)

  // pixel beats repeat at least once and at most a full packet
  `TRD_ASSERT_SAME(a_rep_range, out_valid_o && (status_o == ST_OK || status_o == ST_CLIPPED), repeat_count_o != 8'd0 && (!repeat_count_o[7] || repeat_count_o == 8'd128))

  // a clipped packet is always the end of the image
  `TRD_ASSERT_SAME(a_clip_last, out_valid_o && status_o == ST_CLIPPED, last_pixel_o)

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb import trd_pkg::*;;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT     = 19;
  localparam int HOLD_CYCLES  = 150;
  localparam int STUCK_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 12;
  localparam int RANDOM_BYTES = 200;

  // expected pixel beats, worked out byte by byte from the file stream
  class pixel_scoreboard;
    dec_state_t  st;
    pixel_out_t  pending[$];
    int unsigned n_used;
    int unsigned n_pixels;
    int unsigned n_clipped;
    int unsigned n_errors;
    int unsigned n_images;
    int unsigned n_fail;

    function new();
      st = DEC_RESET;
    endfunction

    // error beat ends the file until the next restart
    function void raise_error(status_e code);
      pixel_out_t r;
      r = '0;
      r.last_pixel = 1'b1;
      r.status     = code;
      r.top_origin = st.origin;
      st.phase     = PH_DONE;
      pending.push_back(r);
      n_errors++;
    endfunction

    function void start_data();
      st.byte_idx = 2'd0;
      st.gather   = '0;
      if (st.compressed) begin
        st.phase = PH_PACKET;
      end else begin
        st.phase    = PH_PIXEL;
        st.pkt_run  = 1'b0;
        st.pkt_left = 8'd0;
      end
    endfunction

    function void header_step(logic [7:0] b);
      logic [4:0]  pos;
      logic [31:0] lim;
      pos = st.hdr_pos;
      lim = 32'd1 << DIM_BITS;
      if (st.hdr_pos < HDR_DESC) st.hdr_pos++;
      case (pos)
        HDR_ID_LEN: st.id_skip = b;
        HDR_CMAP_TYPE: if (b != 8'd0) raise_error(ST_BAD_HEADER);
        HDR_IMG_TYPE: begin
          if (b == IMG_TYPE_RAW) st.compressed = 1'b0;
          else if (b == IMG_TYPE_RLE) st.compressed = 1'b1;
          else raise_error(ST_BAD_HEADER);
        end
        HDR_WIDTH_LO: st.width = {8'h00, b};
        HDR_WIDTH_HI: st.width[15:8] = b;
        HDR_HEIGHT_LO: st.height = {8'h00, b};
        HDR_HEIGHT_HI: begin
          st.height[15:8] = b;
          if (32'(st.width) >= lim || 32'(st.height) >= lim) raise_error(ST_BAD_HEADER);
          else if (st.width == '0 || st.height == '0) raise_error(ST_ZERO_DIM);
        end
        HDR_BPP: begin
          if (b == BPP_24) st.pix_bytes = PIX_BYTES_24;
          else if (b == BPP_32) st.pix_bytes = PIX_BYTES_32;
          else raise_error(ST_BAD_HEADER);
        end
        HDR_DESC: begin
          if (b[7:6] != 2'b00) begin
            raise_error(ST_BAD_HEADER);
          end else begin
            st.origin      = b[5];
            st.pixels_left = 32'(st.width) * 32'(st.height);
            if (st.id_skip != 8'd0) st.phase = PH_IDSKIP;
            else start_data();
          end
        end
        default: ;
      endcase
    endfunction

    // gather one pixel, then emit it with its repeat count
    function void pixel_step(logic [7:0] b);
      int          idx;
      logic [31:0] g;
      logic [31:0] rep;
      bit          clipped;
      pixel_out_t  r;
      idx = int'(st.byte_idx);
      st.gather = st.gather | (32'(b) << (8 * idx));
      idx++;
      if (idx < int'(st.pix_bytes)) begin
        st.byte_idx = 2'(idx);
        return;
      end
      g           = st.gather;
      st.byte_idx = 2'd0;
      st.gather   = '0;
      clipped     = 1'b0;
      if (st.compressed && st.pkt_run) begin
        rep = 32'(st.pkt_left);
        if (rep > st.pixels_left) begin
          rep     = st.pixels_left;
          clipped = 1'b1;
        end
        st.pixels_left -= rep;
        st.pkt_left = 8'd0;
      end else begin
        rep = 32'd1;
        st.pixels_left -= 32'd1;
        if (st.compressed) begin
          if (st.pkt_left > 8'd0) st.pkt_left--;
          if (st.pixels_left == '0 && st.pkt_left > 8'd0) clipped = 1'b1;
        end
      end
      r.red          = g[23:16];
      r.green        = g[15:8];
      r.blue         = g[7:0];
      r.alpha        = (st.pix_bytes == PIX_BYTES_32) ? g[31:24] : 8'h00;
      r.repeat_count = rep[7:0];
      r.last_pixel   = (st.pixels_left == '0);
      r.status       = clipped ? ST_CLIPPED : ST_OK;
      r.top_origin   = st.origin;
      pending.push_back(r);
      n_pixels++;
      if (clipped) n_clipped++;
      if (st.pixels_left == '0) begin
        st.phase = PH_DONE;
        n_images++;
      end else if (st.compressed && st.pkt_left == 8'd0) begin
        st.phase = PH_PACKET;
      end
    endfunction

    // one accepted input beat
    function void note_byte(logic [7:0] b, logic sof);
      if (sof) st = DEC_RESET;
      if (st.phase != PH_DONE) n_used++;
      case (st.phase)
        PH_HEADER: header_step(b);
        PH_IDSKIP: begin
          st.id_skip = st.id_skip - 8'd1;
          if (st.id_skip == 8'd0) start_data();
        end
        PH_PACKET: begin
          st.pkt_run  = b[7];
          st.pkt_left = b[7] ? ({1'b0, b[6:0]} + 8'd1) : (b + 8'd1);
          st.byte_idx = 2'd0;
          st.gather   = '0;
          st.phase    = PH_PIXEL;
        end
        PH_PIXEL: pixel_step(b);
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        n_fail++;
      end
    endfunction

    // one accepted result beat against the oldest expectation
    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none actual %h", $time, got);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("alpha", want.alpha, got.alpha);
      cmp_field("repeat_count", want.repeat_count, got.repeat_count);
      cmp_field("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
      cmp_field("status", 8'(want.status), 8'(got.status));
      cmp_field("top_origin", 8'(want.top_origin), 8'(got.top_origin));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic [7:0] data_byte_i;
  logic       start_of_file_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic [7:0] alpha_o;
  logic [7:0] repeat_count_o;
  logic       last_pixel_o;
  logic [1:0] status_o;
  logic       top_origin_o;
  logic       out_valid_o;
  logic       out_stall_i;

  bit calm;
  bit hold_req;
  int stuck_cycles;

  pixel_scoreboard sb = new();

  tga_rle_pixel_decoder u_top (.*);

  // clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    pixel_out_t beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beat.red          = red_o;
      beat.green        = green_o;
      beat.blue         = blue_o;
      beat.alpha        = alpha_o;
      beat.repeat_count = repeat_count_o;
      beat.last_pixel   = last_pixel_o;
      beat.status       = status_e'(status_o);
      beat.top_origin   = top_origin_o;
      sb.check_result(beat);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // one input beat, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    start_of_file_i <= sof;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, sof);
  endtask

  task automatic send_pixel(input int pb);
    repeat (pb) send_byte(8'($urandom), 1'b0);
  endtask

  // 18 header bytes then the id field
  task automatic send_header(input logic [7:0] id_len, input logic [7:0] cmap,
                             input logic [7:0] img_type, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] bpp,
                             input logic [7:0] desc);
    send_byte(id_len, 1'b1);
    send_byte(cmap, 1'b0);
    send_byte(img_type, 1'b0);
    repeat (9) send_byte(8'($urandom), 1'b0);
    send_byte(w[7:0], 1'b0);
    send_byte(w[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(bpp, 1'b0);
    send_byte(desc, 1'b0);
    repeat (id_len) send_byte(8'($urandom), 1'b0);
  endtask

  // pixel data, raw or packets, cut short once the budget is spent
  task automatic send_body(input bit rle, input int pb, input longint total,
                           input int budget);
    longint     left;
    int         used;
    int         cnt;
    logic [7:0] head;
    left = total;
    used = 0;
    while (left > 0 && used < budget) begin
      if (!rle) begin
        send_pixel(pb);
        left--;
        used += pb;
      end else begin
        head[7]   = 1'($urandom_range(1));
        head[6:0] = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(7));
        cnt = int'(head[6:0]) + 1;
        send_byte(head, 1'b0);
        used++;
        if (head[7]) begin
          send_pixel(pb);
          used += pb;
          left -= (cnt < left) ? cnt : left;
        end else begin
          for (int i = 0; i < cnt && left > 0 && used < budget; i++) begin
            send_pixel(pb);
            left--;
            used += pb;
          end
        end
      end
    end
    // a few stray beats: mid-pixel cut or ignored trailer
    repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
  endtask

  // stimulus
  initial begin : stimulus
    int         k;
    int         files;
    int         target;
    bit         rle;
    int         pb;
    logic [7:0] desc;
    logic [7:0] id_len;
    logic [7:0] bad;
    logic [15:0] w;
    logic [15:0] h;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    start_of_file_i = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    stuck_cycles    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header errors, each found at its own byte
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_header(8'd0, 8'd0, 8'd3, 16'd1, 16'd1, BPP_24, 8'h00);
    send_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd0, 16'd5, BPP_24, 8'h00);
    send_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd7, 16'd0, BPP_32, 8'h00);
    send_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd1, 16'd1, 8'd16, 8'h00);
    send_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd1, 16'd1, BPP_24, 8'h60);
    send_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd1, 16'd1, BPP_32, 8'h80);

    // raw image with id field and top origin
    send_header(8'd2, 8'd0, IMG_TYPE_RAW, 16'd2, 16'd1, BPP_24, 8'h20);
    send_body(1'b0, 3, 2, 100);

    // run then raw packet overrunning the image end
    send_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd2, 16'd2, BPP_32, 8'h1F);
    send_byte(8'h82, 1'b0);
    send_pixel(4);
    send_byte(8'h02, 1'b0);
    send_pixel(4);
    send_byte(8'h55, 1'b0);

    // longest run clipped to a one-pixel image
    send_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd1, 16'd1, BPP_24, 8'h30);
    send_byte(8'hFF, 1'b0);
    send_pixel(3);

    // largest dimensions, cut off by the next file
    send_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'hFFFF, 16'hFFFF, BPP_32, 8'h3F);
    send_byte(8'hFF, 1'b0);
    send_pixel(4);
    send_byte(8'h7F, 1'b0);
    send_pixel(4);
    send_pixel(4);

    // long id field
    send_header(8'd40, 8'd0, IMG_TYPE_RAW, 16'd1, 16'd1, BPP_32, 8'h00);
    send_body(1'b0, 4, 1, 100);

    // receiver holds off while a raw image streams in
    hold_req = 1'b1;
    send_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd4, 16'd4, BPP_24, 8'h00);
    send_body(1'b0, 3, 16, 1000);

    // random files, mostly well formed
    files  = 0;
    target = sb.n_used + RANDOM_BYTES;
    while (sb.n_used < target) begin
      calm   = (files >= 2 && files < 5);
      k      = $urandom_range(99);
      rle    = 1'($urandom_range(1));
      pb     = $urandom_range(1) ? 4 : 3;
      desc   = {2'b00, 6'($urandom)};
      id_len = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
      if (k < 65) begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 4));
        send_header(id_len, 8'd0, rle ? IMG_TYPE_RLE : IMG_TYPE_RAW, w, h,
                    (pb == 4) ? BPP_32 : BPP_24, desc);
        send_body(rle, pb, longint'(w) * longint'(h), 400);
      end else if (k < 80) begin
        // one broken header field (the dimension case may draw a valid header)
        case ($urandom_range(4))
          0: send_header(id_len, 8'($urandom_range(1, 255)), IMG_TYPE_RAW, 16'd1, 16'd1,
                         BPP_24, desc);
          1: begin
            do bad = 8'($urandom); while (bad == IMG_TYPE_RAW || bad == IMG_TYPE_RLE);
            send_header(id_len, 8'd0, bad, 16'd1, 16'd1, BPP_24, desc);
          end
          2: send_header(id_len, 8'd0, IMG_TYPE_RLE, $urandom_range(1) ? 16'd0 : 16'd3,
                         16'($urandom_range(1)), BPP_32, desc);
          3: begin
            do bad = 8'($urandom); while (bad == BPP_24 || bad == BPP_32);
            send_header(id_len, 8'd0, IMG_TYPE_RAW, 16'd2, 16'd2, bad, desc);
          end
          default: send_header(id_len, 8'd0, IMG_TYPE_RLE, 16'd2, 16'd2, BPP_24,
                               {2'($urandom_range(1, 3)), 6'($urandom)});
        endcase
      end else if (k < 90) begin
        // wide random dimensions, truncated
        w = 16'($urandom);
        h = 16'($urandom);
        send_header(id_len, 8'd0, IMG_TYPE_RLE, w, h, (pb == 4) ? BPP_32 : BPP_24, desc);
        send_body(1'b1, pb, longint'(w) * longint'(h), 40);
      end else begin
        // noise beats
        repeat ($urandom_range(1, 20))
          send_byte(8'($urandom), ($urandom_range(9) == 0));
      end
      files++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // drain, then a few more cycles for any stray beat
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d parsed bytes in %0d random files: %0d pixel beats, %0d clipped",
             sb.n_used, files, sb.n_pixels, sb.n_clipped);
    $display("%0d images completed, %0d header errors", sb.n_images, sb.n_errors);
    if (sb.n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
